/* rtl/mcs_pkg.sv */
`timescale 1ns / 1ps

package mcs_pkg;

	localparam int INTERVAL_W = 24;
	localparam int BPB_W      = 6;
	localparam int SUBDIV_W   = 5;
	localparam int BLOCK_W    = 14;
	localparam int KIND_W     = 2;
	localparam int TOTAL_W    = 64;
	localparam int BIT_IDX_W  = $clog2(TOTAL_W);
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	localparam logic [CFG_IDX_W-1:0] REG_BEAT_INTERVAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SUB_INTERVAL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BEATS_PER_BAR = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SUBDIVISIONS  = 2'd3;

	localparam logic [INTERVAL_W-1:0] RST_BEAT_INTERVAL = 24'd22050;
	localparam logic [INTERVAL_W-1:0] RST_SUB_INTERVAL  = 24'd22050;
	localparam logic [BPB_W-1:0]      RST_BEATS_PER_BAR = 6'd4;
	localparam logic [SUBDIV_W-1:0]   RST_SUBDIVISIONS  = 5'd1;

	localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SUB     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REGULAR = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ACCENT  = 2'd3;

	localparam logic OP_ADVANCE = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	typedef struct packed {
		logic load;
		logic step;
		logic commit;
	} mcs_cmd_t;

	typedef struct packed {
		logic restart;
		logic div_last;
	} mcs_sts_t;

endpackage

/* rtl/mcs_if.sv */
`timescale 1ns / 1ps

interface mcs_item_if import mcs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               operation;
	logic [BLOCK_W-1:0] block_size;

	modport source (output valid, output operation, output block_size, input ready);
	modport sink (input valid, input operation, input block_size, output ready);
endinterface

interface mcs_result_if import mcs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  click_kind;
	logic [BLOCK_W-1:0] click_offset;
	logic [BPB_W-1:0]   beat_in_bar;

	modport source (output valid, output click_kind, output click_offset,
		output beat_in_bar, input ready);
	modport sink (input valid, input click_kind, input click_offset,
		input beat_in_bar, output ready);
endinterface

interface mcs_cfg_if import mcs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/mcs_ctrl.sv */
`timescale 1ns / 1ps

module mcs_ctrl
	import mcs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  mcs_sts_t sts,
	output mcs_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free  = !out_valid_q || out_ready;
	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign cmd.load   = in_ready && in_valid;
	assign cmd.step   = (state_q == ST_DIV) && !sts.restart;
	assign cmd.commit = (state_q == ST_FIN) && slot_free;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DIV;
			end
			ST_DIV: begin
				// restart skips the remainder pass
				if (sts.restart || sts.div_last) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (slot_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || out_ready))
		else $error("result committed over an untaken word");

	a_div_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && !sts.restart && !sts.div_last) |=> state_q == ST_DIV)
		else $error("remainder pass left early");

	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FIN))
		else $error("result word raised outside finish state");

endmodule

/* rtl/mcs_dp.sv */
`timescale 1ns / 1ps

module mcs_dp
	import mcs_pkg::*;
#(
	parameter int MAX_BLOCK = 8192
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mcs_cmd_t              cmd,
	output mcs_sts_t              sts,
	input  logic                  operation,
	input  logic [BLOCK_W-1:0]    block_size,
	input  logic [INTERVAL_W-1:0] beat_interval,
	input  logic [INTERVAL_W-1:0] sub_interval,
	input  logic [BPB_W-1:0]      beats_per_bar,
	input  logic [SUBDIV_W-1:0]   subdivisions,
	output logic [KIND_W-1:0]     click_kind,
	output logic [BLOCK_W-1:0]    click_offset,
	output logic [BPB_W-1:0]      beat_in_bar
);

	localparam logic [16:0] BLK_LIMIT = 17'(MAX_BLOCK);

	logic [TOTAL_W-1:0]    total_q;
	logic [BPB_W-1:0]      beat_q;
	logic [SUBDIV_W-1:0]   sub_q;
	logic                  op_q;
	logic [BLOCK_W-1:0]    blk_q;
	logic [BIT_IDX_W-1:0]  cnt_q;
	logic [INTERVAL_W-1:0] rem_b_q;
	logic [INTERVAL_W-1:0] rem_s_q;
	logic [KIND_W-1:0]     kind_q;
	logic [BLOCK_W-1:0]    offset_q;
	logic [BPB_W-1:0]      bib_q;

	logic [BLOCK_W-1:0]    blk_sat;
	logic [INTERVAL_W-1:0] bi;
	logic [INTERVAL_W-1:0] si;
	logic                  nbit;
	logic [INTERVAL_W:0]   sh_b;
	logic [INTERVAL_W:0]   sh_s;
	logic [INTERVAL_W-1:0] rem_b_d;
	logic [INTERVAL_W-1:0] rem_s_d;
	logic [SUBDIV_W-1:0]   sub_c;
	logic                  sub_hit;
	logic                  beat_hit;
	logic [INTERVAL_W-1:0] off_b;
	logic [INTERVAL_W-1:0] off_s;
	logic [KIND_W-1:0]     kind_d;
	logic [BLOCK_W-1:0]    offset_d;
	logic [BPB_W-1:0]      beat_d;
	logic [SUBDIV_W-1:0]   sub_d;

	assign blk_sat = ({3'b000, block_size} > BLK_LIMIT) ? BLK_LIMIT[BLOCK_W-1:0] : block_size;
	assign bi = (beat_interval == '0) ? INTERVAL_W'(1) : beat_interval;
	assign si = (sub_interval == '0) ? INTERVAL_W'(1) : sub_interval;

	// restoring remainder step, one total bit per cycle, msb first
	assign nbit    = total_q[cnt_q];
	assign sh_b    = {rem_b_q, nbit};
	assign sh_s    = {rem_s_q, nbit};
	assign rem_b_d = (sh_b >= {1'b0, bi}) ? INTERVAL_W'(sh_b - {1'b0, bi}) : sh_b[INTERVAL_W-1:0];
	assign rem_s_d = (sh_s >= {1'b0, si}) ? INTERVAL_W'(sh_s - {1'b0, si}) : sh_s[INTERVAL_W-1:0];

	assign sts.restart  = op_q;
	assign sts.div_last = (cnt_q == '0);

	assign sub_c    = (sub_q > subdivisions) ? subdivisions : sub_q;
	assign sub_hit  = (subdivisions > SUBDIV_W'(1))
		&& (({1'b0, rem_s_q} + (INTERVAL_W + 1)'(blk_q)) >= {1'b0, si})
		&& (sub_c != subdivisions);
	assign beat_hit = ({1'b0, rem_b_q} + (INTERVAL_W + 1)'(blk_q)) >= {1'b0, bi};
	assign off_b    = bi - rem_b_q;
	assign off_s    = si - rem_s_q;

	always_comb begin
		kind_d   = KIND_NONE;
		offset_d = '0;
		beat_d   = beat_q;
		sub_d    = sub_c;
		priority if (op_q == OP_RESTART) begin
			beat_d = beats_per_bar;
			sub_d  = subdivisions;
		end else if (sub_hit) begin
			kind_d   = KIND_SUB;
			offset_d = off_s[BLOCK_W-1:0];
			sub_d    = sub_c + SUBDIV_W'(1);
		end else if (beat_hit) begin
			offset_d = off_b[BLOCK_W-1:0];
			sub_d    = SUBDIV_W'(1);
			if (beat_q >= beats_per_bar) begin
				kind_d = KIND_ACCENT;
				beat_d = BPB_W'(1);
			end else begin
				kind_d = KIND_REGULAR;
				beat_d = beat_q + BPB_W'(1);
			end
		end else begin
			kind_d = KIND_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			beat_q  <= RST_BEATS_PER_BAR;
			sub_q   <= RST_SUBDIVISIONS;
			op_q    <= OP_ADVANCE;
			cnt_q   <= '0;
		end else begin
			if (cmd.load) begin
				op_q  <= operation;
				cnt_q <= '1;
				if (operation == OP_RESTART) total_q <= '0;
				else total_q <= total_q + TOTAL_W'(blk_sat);
			end else if (cmd.step) begin
				cnt_q <= cnt_q - BIT_IDX_W'(1);
			end
			if (cmd.commit) begin
				beat_q <= beat_d;
				sub_q  <= sub_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			blk_q   <= blk_sat;
			rem_b_q <= '0;
			rem_s_q <= '0;
		end else if (cmd.step) begin
			rem_b_q <= rem_b_d;
			rem_s_q <= rem_s_d;
		end
		if (cmd.commit) begin
			kind_q   <= kind_d;
			offset_q <= offset_d;
			bib_q    <= beat_d;
		end
	end

	assign click_kind   = kind_q;
	assign click_offset = offset_q;
	assign beat_in_bar  = bib_q;

endmodule

/* rtl/metronome_click_scheduler_core.sv */
`timescale 1ns / 1ps
// metronome click scheduler: one result word per input word
// item_ch carries an operation (advance by block_size samples, capped at MAX_BLOCK, or restart) and
// a block size; result_ch returns the click kind, its offset in the block and
// the beat counter after the step. cfg_ch writes beat_interval, sub_interval,
// beats_per_bar and subdivisions by index 0..3 and is always ready; write it
// only while no word is in flight.
// an advance word is accepted in the load edge; in the remainder pass two
// restoring remainder units shift the 64-bit sample total in one bit per cycle
// (one for the beat interval, one for the subdivision interval), and a finish
// step then decides the click. a restart word skips the remainder pass before
// the finish step. one word is worked at a time: a new input word is accepted
// only after the finish step of the last one.
// the result sits in an output register; a new input word is accepted while it
// waits, and a stalled receiver holds the finish step until the word is taken.
// reset clears the sample total, sets the beat and subdivision counters to the
// reset values of beats_per_bar and subdivisions and loads the config registers
// with their reset values; the block, remainder and result registers have no reset.
module metronome_click_scheduler_core
	import mcs_pkg::*;
#(
	parameter int MAX_BLOCK = 8192
) (
	input logic            clk,
	input logic            arst_n,
	mcs_item_if.sink       item_ch,
	mcs_result_if.source   result_ch,
	mcs_cfg_if.sink        cfg_ch
);

	logic [INTERVAL_W-1:0] beat_interval_q;
	logic [INTERVAL_W-1:0] sub_interval_q;
	logic [BPB_W-1:0]      beats_per_bar_q;
	logic [SUBDIV_W-1:0]   subdivisions_q;
	mcs_cmd_t              cmd;
	mcs_sts_t              sts;

	assign cfg_ch.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_interval_q <= RST_BEAT_INTERVAL;
			sub_interval_q  <= RST_SUB_INTERVAL;
			beats_per_bar_q <= RST_BEATS_PER_BAR;
			subdivisions_q  <= RST_SUBDIVISIONS;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				REG_BEAT_INTERVAL: beat_interval_q <= cfg_ch.data[INTERVAL_W-1:0];
				REG_SUB_INTERVAL:  sub_interval_q  <= cfg_ch.data[INTERVAL_W-1:0];
				REG_BEATS_PER_BAR: beats_per_bar_q <= cfg_ch.data[BPB_W-1:0];
				REG_SUBDIVISIONS:  subdivisions_q  <= cfg_ch.data[SUBDIV_W-1:0];
				default: ;
			endcase
		end
	end

	mcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_ch.valid),
		.in_ready  (item_ch.ready),
		.out_valid (result_ch.valid),
		.out_ready (result_ch.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mcs_dp #(
		.MAX_BLOCK (MAX_BLOCK)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.operation     (item_ch.operation),
		.block_size    (item_ch.block_size),
		.beat_interval (beat_interval_q),
		.sub_interval  (sub_interval_q),
		.beats_per_bar (beats_per_bar_q),
		.subdivisions  (subdivisions_q),
		.click_kind    (result_ch.click_kind),
		.click_offset  (result_ch.click_offset),
		.beat_in_bar   (result_ch.beat_in_bar)
	);

endmodule
